>>> hw/rtl/poi_pkg.sv
package poi_pkg;

    // Fixed-point widths
    localparam int VEL_W   = 24;
    localparam int DT_W    = 18;
    localparam int POS_W   = 32;
    localparam int GAIN_W  = 16;
    localparam int Q_W     = 16;
    localparam int ACC_W   = 58;   // multiplier product / accumulator
    localparam int ANG_W   = 39;   // unreduced angle, Q.28
    localparam int CS_W    = 34;   // CORDIC x/y, Q2.30
    localparam int CZ_W    = 32;   // CORDIC residual angle, Q.28
    localparam int ATAN_LEN = 24;

    // Angle constants, Q.28 rad
    localparam logic signed [ANG_W-1:0] PI_Q28      = 39'sd843314857;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 39'sd421657428;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 39'sd1686629713;
    // CORDIC start gain, Q2.30
    localparam logic signed [CS_W-1:0]  CORDIC_K_Q30 = 34'sd652032874;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN = 2'd1;

    localparam logic [GAIN_W-1:0] X_GAIN_RESET       = 16'd21365;
    localparam logic [GAIN_W-1:0] HEADING_GAIN_RESET = 16'd16548;

    // arctan(2^-i) in Q.28
    function automatic logic signed [CZ_W-1:0] atan_q28(input logic [4:0] idx);
        logic signed [CZ_W-1:0] r;
        unique case (idx)
            5'd0:  r = 32'sd210828714;
            5'd1:  r = 32'sd124459457;
            5'd2:  r = 32'sd65760959;
            5'd3:  r = 32'sd33381290;
            5'd4:  r = 32'sd16755422;
            5'd5:  r = 32'sd8385879;
            5'd6:  r = 32'sd4193963;
            5'd7:  r = 32'sd2097109;
            5'd8:  r = 32'sd1048571;
            5'd9:  r = 32'sd524287;
            5'd10: r = 32'sd262144;
            5'd11: r = 32'sd131072;
            5'd12: r = 32'sd65536;
            5'd13: r = 32'sd32768;
            5'd14: r = 32'sd16384;
            5'd15: r = 32'sd8192;
            5'd16: r = 32'sd4096;
            5'd17: r = 32'sd2048;
            5'd18: r = 32'sd1024;
            5'd19: r = 32'sd512;
            5'd20: r = 32'sd256;
            5'd21: r = 32'sd128;
            5'd22: r = 32'sd64;
            5'd23: r = 32'sd32;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 58'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -58'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] sat16(input logic signed [CS_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 34'sd32767)
            r = 16'sh7FFF;
        else if (v < -34'sd32768)
            r = 16'sh8000;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/planar_odometry_integrator_top.sv
// Planar dead-reckoning integrator. One item (body velocity, yaw rate, interval)
// is taken at a time; in_stall stays high until its result has been loaded into
// the output register. Each item makes two sine/cosine passes through one shared
// add/shift CORDIC unit (1 offset step, 7 modulo-2pi reduction steps, 1 fold,
// CORDIC_STEPS rotations, 1 sign fix each) and nine multiply/accumulate
// operations through one 32x32 multiplier, then loads the output register; the
// next item is accepted in the idle state. CORDIC_STEPS is capped at 24.
// A result waiting on out_stall does not block the next item from being accepted
// and worked on. Position and heading saturate at the 32-bit signed range and
// reset to zero.
module planar_odometry_integrator_top
    import poi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [VEL_W-1:0]     vel_x,
    input  logic signed [VEL_W-1:0]     vel_y,
    input  logic signed [VEL_W-1:0]     yaw_rate,
    input  logic        [DT_W-1:0]      interval,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [POS_W-1:0]     pos_x_out,
    output logic signed [POS_W-1:0]     pos_y_out,
    output logic signed [Q_W-1:0]       quat_z,
    output logic signed [Q_W-1:0]       quat_w,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic        [CFG_IDX_W-1:0] cfg_index,
    input  logic        [GAIN_W-1:0]    cfg_data
);

    localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam logic [4:0] LAST_STEP = 5'(NSTEPS - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RED_INIT = 4'd1;
    localparam logic [3:0] S_RED      = 4'd2;
    localparam logic [3:0] S_FOLD     = 4'd3;
    localparam logic [3:0] S_CORD     = 4'd4;
    localparam logic [3:0] S_NEG      = 4'd5;
    localparam logic [3:0] S_MUL      = 4'd6;
    localparam logic [3:0] S_ACC      = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    localparam logic [3:0] OP_VXC  = 4'd0;
    localparam logic [3:0] OP_VYS  = 4'd1;
    localparam logic [3:0] OP_VXS  = 4'd2;
    localparam logic [3:0] OP_VYC  = 4'd3;
    localparam logic [3:0] OP_RXDT = 4'd4;
    localparam logic [3:0] OP_RYDT = 4'd5;
    localparam logic [3:0] OP_WZDT = 4'd6;
    localparam logic [3:0] OP_PXG  = 4'd7;
    localparam logic [3:0] OP_HDG  = 4'd8;

    logic [3:0]               state_reg;
    logic                     phase_reg;
    logic [3:0]               mop_reg;
    logic [2:0]               k_reg;
    logic [4:0]               i_reg;
    logic                     neg_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic signed [CS_W-1:0]   cx_reg;
    logic signed [CS_W-1:0]   cy_reg;
    logic signed [CZ_W-1:0]   cz_reg;
    logic signed [ACC_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [25:0]       rx_reg;
    logic signed [25:0]       ry_reg;
    logic signed [VEL_W-1:0]  vx_reg;
    logic signed [VEL_W-1:0]  vy_reg;
    logic signed [VEL_W-1:0]  wz_reg;
    logic        [DT_W-1:0]   dt_reg;
    logic signed [POS_W-1:0]  posx_reg;
    logic signed [POS_W-1:0]  posy_reg;
    logic signed [POS_W-1:0]  head_reg;
    logic signed [ANG_W-1:0]  ang_reg;
    logic signed [POS_W-1:0]  px_reg;
    logic        [GAIN_W-1:0] xgain_reg;
    logic        [GAIN_W-1:0] hgain_reg;
    logic                     out_valid_reg;
    logic signed [POS_W-1:0]  pos_x_out_reg;
    logic signed [POS_W-1:0]  pos_y_out_reg;
    logic signed [Q_W-1:0]    quat_z_reg;
    logic signed [Q_W-1:0]    quat_w_reg;

    logic in_accept;
    logic out_load;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign pos_x_out = pos_x_out_reg;
    assign pos_y_out = pos_y_out_reg;
    assign quat_z    = quat_z_reg;
    assign quat_w    = quat_w_reg;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // Angle source and offset to make it non-negative before reduction
    logic signed [ANG_W-1:0] ang_src;
    logic signed [ANG_W-1:0] red_init_next;
    assign ang_src = phase_reg ? ang_reg : {{3{head_reg[POS_W-1]}}, head_reg, 4'b0000};
    assign red_init_next = ang_src[ANG_W-1] ? (ang_src + (TWO_PI_Q28 <<< 6)) : ang_src;

    // Reduction step: conditional subtract of 2pi << k
    logic signed [ANG_W-1:0] red_tk;
    assign red_tk = TWO_PI_Q28 <<< k_reg;

    // Fold into [-pi/2, pi/2]
    logic signed [ANG_W-1:0] fold_w;
    logic signed [ANG_W-1:0] fold_v;
    logic                    fold_neg;
    always_comb
    begin
        fold_w   = (z_reg > PI_Q28) ? (z_reg - TWO_PI_Q28) : z_reg;
        fold_v   = fold_w;
        fold_neg = 1'b0;
        if (fold_w > HALF_PI_Q28)
        begin
            fold_v   = fold_w - PI_Q28;
            fold_neg = 1'b1;
        end
        else if (fold_w < -HALF_PI_Q28)
        begin
            fold_v   = fold_w + PI_Q28;
            fold_neg = 1'b1;
        end
    end

    // Shared CORDIC rotation step
    logic signed [CS_W-1:0] cx_sh;
    logic signed [CS_W-1:0] cy_sh;
    logic signed [CZ_W-1:0] atan_i;
    assign cx_sh  = cx_reg >>> i_reg;
    assign cy_sh  = cy_reg >>> i_reg;
    assign atan_i = atan_q28(i_reg);

    // Shared multiplier operand select
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_full;
    always_comb
    begin
        unique case (mop_reg)
            OP_VXC:  begin mul_a = 32'(vx_reg); mul_b = cx_reg[31:0]; end
            OP_VYS:  begin mul_a = 32'(vy_reg); mul_b = cy_reg[31:0]; end
            OP_VXS:  begin mul_a = 32'(vx_reg); mul_b = cy_reg[31:0]; end
            OP_VYC:  begin mul_a = 32'(vy_reg); mul_b = cx_reg[31:0]; end
            OP_RXDT: begin mul_a = 32'(rx_reg); mul_b = {14'd0, dt_reg}; end
            OP_RYDT: begin mul_a = 32'(ry_reg); mul_b = {14'd0, dt_reg}; end
            OP_WZDT: begin mul_a = 32'(wz_reg); mul_b = {14'd0, dt_reg}; end
            OP_PXG:  begin mul_a = posx_reg;    mul_b = {16'd0, xgain_reg}; end
            OP_HDG:  begin mul_a = head_reg;    mul_b = {16'd0, hgain_reg}; end
            default: begin mul_a = 32'sd0;      mul_b = 32'sd0; end
        endcase
    end
    assign mul_full = mul_a * mul_b;

    // Accumulate/round results
    logic signed [ACC_W-1:0] acc_sub;
    logic signed [ACC_W-1:0] acc_add;
    logic signed [ACC_W-1:0] rnd16;
    logic signed [ACC_W-1:0] rnd8;
    logic signed [ACC_W-1:0] rnd14;
    logic signed [ACC_W-1:0] rnd11;
    assign acc_sub = (acc_reg - prod_reg + 58'sd536870912) >>> 30;
    assign acc_add = (acc_reg + prod_reg + 58'sd536870912) >>> 30;
    assign rnd16   = (prod_reg + 58'sd32768) >>> 16;
    assign rnd8    = (prod_reg + 58'sd128) >>> 8;
    assign rnd14   = (prod_reg + 58'sd8192) >>> 14;
    assign rnd11   = (prod_reg + 58'sd1024) >>> 11;

    // Quaternion rounding
    logic signed [CS_W-1:0] qz_rnd;
    logic signed [CS_W-1:0] qw_rnd;
    assign qz_rnd = (cy_reg + 34'sd16384) >>> 15;
    assign qw_rnd = (cx_reg + 34'sd16384) >>> 15;

    // Sequencer and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            mop_reg       <= OP_VXC;
            k_reg         <= 3'd0;
            i_reg         <= 5'd0;
            out_valid_reg <= 1'b0;
            posx_reg      <= '0;
            posy_reg      <= '0;
            head_reg      <= '0;
            xgain_reg     <= X_GAIN_RESET;
            hgain_reg     <= HEADING_GAIN_RESET;
        end
        else
        begin
            // configuration transaction
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_X_GAIN)
                    xgain_reg <= cfg_data;
                else if (cfg_index == CFG_HEADING_GAIN)
                    hgain_reg <= cfg_data;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        phase_reg <= 1'b0;
                        state_reg <= S_RED_INIT;
                    end
                end
                S_RED_INIT:
                begin
                    k_reg     <= 3'd6;
                    state_reg <= S_RED;
                end
                S_RED:
                begin
                    k_reg <= k_reg - 3'd1;
                    if (k_reg == 3'd0)
                        state_reg <= S_FOLD;
                end
                S_FOLD:
                begin
                    i_reg     <= 5'd0;
                    state_reg <= S_CORD;
                end
                S_CORD:
                begin
                    i_reg <= i_reg + 5'd1;
                    if (i_reg == LAST_STEP)
                        state_reg <= S_NEG;
                end
                S_NEG:
                begin
                    mop_reg   <= OP_VXC;
                    state_reg <= phase_reg ? S_OUT : S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    unique case (mop_reg)
                        OP_RXDT: posx_reg <= sat32(58'(posx_reg) + rnd16);
                        OP_RYDT: posy_reg <= sat32(58'(posy_reg) + rnd16);
                        OP_WZDT: head_reg <= sat32(58'(head_reg) + rnd8);
                        default: ;
                    endcase
                    mop_reg <= mop_reg + 4'd1;
                    if (mop_reg == OP_HDG)
                    begin
                        phase_reg <= 1'b1;
                        state_reg <= S_RED_INIT;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            vx_reg <= vel_x;
            vy_reg <= vel_y;
            wz_reg <= yaw_rate;
            dt_reg <= interval;
        end

        unique case (state_reg)
            S_RED_INIT:
            begin
                z_reg <= red_init_next;
            end
            S_RED:
            begin
                if (z_reg >= red_tk)
                    z_reg <= z_reg - red_tk;
            end
            S_FOLD:
            begin
                cz_reg  <= fold_v[CZ_W-1:0];
                neg_reg <= fold_neg;
                cx_reg  <= CORDIC_K_Q30;
                cy_reg  <= '0;
            end
            S_CORD:
            begin
                if (!cz_reg[CZ_W-1])
                begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - atan_i;
                end
                else
                begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + atan_i;
                end
            end
            S_NEG:
            begin
                if (neg_reg)
                begin
                    cx_reg <= -cx_reg;
                    cy_reg <= -cy_reg;
                end
            end
            S_MUL:
            begin
                prod_reg <= mul_full[ACC_W-1:0];
            end
            S_ACC:
            begin
                unique case (mop_reg)
                    OP_VXC:  acc_reg <= prod_reg;
                    OP_VYS:  rx_reg  <= acc_sub[25:0];
                    OP_VXS:  acc_reg <= prod_reg;
                    OP_VYC:  ry_reg  <= acc_add[25:0];
                    OP_PXG:  px_reg  <= sat32(rnd14);
                    OP_HDG:  ang_reg <= rnd11[ANG_W-1:0];
                    default: ;
                endcase
            end
            default: ;
        endcase

        // result register
        if (out_load)
        begin
            pos_x_out_reg <= px_reg;
            pos_y_out_reg <= posy_reg;
            quat_z_reg    <= sat16(qz_rnd);
            quat_w_reg    <= sat16(qw_rnd);
        end
    end

    // Assertions
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_RED_INIT))
        else $error("accepted item did not start the sequencer");

    a_cord_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CORD) |-> (i_reg <= LAST_STEP))
        else $error("CORDIC step count out of range");

    a_red_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RED) |-> (k_reg <= 3'd6))
        else $error("reduction step out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && out_stall) |=> (state_reg == S_OUT))
        else $error("result overwritten while previous result pending");

    a_mop_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_ACC) |-> (mop_reg <= OP_HDG))
        else $error("multiply operation index out of range");

endmodule
